[rtl/dsa_pkg.sv]
// Shared types and constants for the descriptor slot allocator.
// No dependencies; imported by all modules but dsa_ram.
package dsa_pkg;

  localparam int NUM_SLOTS  = 64;
  localparam int OWNER_BITS = 8;
  localparam int SLOT_W     = $clog2(NUM_SLOTS);
  localparam int CNT_W      = $clog2(NUM_SLOTS + 1);

  // Fixed field widths of the request and result transfers
  localparam int IDX_W   = 6;
  localparam int PID_W   = 8;
  localparam int FREED_W = 7;

  // Request codes
  localparam logic [1:0] REQ_ALLOC   = 2'd0;
  localparam logic [1:0] REQ_RELEASE = 2'd1;
  localparam logic [1:0] REQ_CHOWN   = 2'd2;
  localparam logic [1:0] REQ_QUERY   = 2'd3;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [IDX_W-1:0] fd_index;
    logic [PID_W-1:0] owner_pid;
  } dsa_req_t;

  typedef struct packed {
    logic [IDX_W-1:0]   alloc_index;
    logic [FREED_W-1:0] freed_count;
    logic               fd_valid;
  } dsa_res_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic alloc_step;
    logic rel_issue;
    logic rel_finish;
    logic simple_op;
  } dsa_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic alloc_done;
    logic scan_last;
  } dsa_sts_t;

endpackage

[rtl/dsa_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module dsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/dsa_ctrl.sv]
// Sequencing state machine of the descriptor slot allocator.
// Depends on dsa_pkg; drives dsa_datapath through command and status structs.
module dsa_ctrl
  import dsa_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] req_type,
  input  dsa_sts_t   sts,
  output dsa_cmd_t   cmd,
  output logic       busy
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_ALLOC  = 3'd1;
  localparam logic [2:0] ST_REL    = 3'd2;
  localparam logic [2:0] ST_DRAIN  = 3'd3;
  localparam logic [2:0] ST_SIMPLE = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          unique case (req_type)
            REQ_ALLOC:   state_nxt = ST_ALLOC;
            REQ_RELEASE: state_nxt = ST_REL;
            REQ_CHOWN:   state_nxt = ST_SIMPLE;
            REQ_QUERY:   state_nxt = ST_SIMPLE;
            default:     state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_ALLOC: begin
        cmd.alloc_step = 1'b1;
        if (sts.alloc_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_REL: begin
        cmd.rel_issue = 1'b1;
        if (sts.scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        cmd.rel_finish = 1'b1;
        state_nxt      = ST_IDLE;
      end
      ST_SIMPLE: begin
        cmd.simple_op = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

[rtl/dsa_datapath.sv]
// Slot table, scan counter, owner RAM and result register of the allocator.
// Depends on dsa_pkg and dsa_ram; commanded by dsa_ctrl.
module dsa_datapath
  import dsa_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  dsa_req_t in_req,
  input  dsa_cmd_t cmd,
  output dsa_sts_t sts,
  output logic     out_valid,
  output dsa_res_t out_res
);

  dsa_req_t             req_r, req_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [CNT_W-1:0]     hw_r, hw_nxt;
  logic [NUM_SLOTS-1:0] free_r, free_nxt;
  logic [NUM_SLOTS-1:0] wrt_r, wrt_nxt;
  logic                 pend_r, pend_nxt;
  logic [SLOT_W-1:0]    paddr_r, paddr_nxt;
  logic                 out_valid_r, out_valid_nxt;
  dsa_res_t             res_r, res_nxt;

  logic                  ram_we;
  logic [SLOT_W-1:0]     ram_waddr;
  logic [OWNER_BITS-1:0] ram_q;

  logic [SLOT_W-1:0]     cnt_idx;
  logic [SLOT_W-1:0]     hw_idx;
  logic [SLOT_W-1:0]     req_idx;
  logic [OWNER_BITS-1:0] who;
  logic [OWNER_BITS-1:0] owner_eff;
  logic                  in_mark;
  logic                  alloc_hit;
  logic                  can_extend;
  logic                  rel_match;
  logic                  slot_used;

  assign cnt_idx    = cnt_r[SLOT_W-1:0];
  assign hw_idx     = hw_r[SLOT_W-1:0];
  assign req_idx    = SLOT_W'(req_r.fd_index);
  assign who        = req_r.owner_pid[OWNER_BITS-1:0];
  assign in_mark    = (cnt_r < hw_r);
  assign alloc_hit  = in_mark && free_r[cnt_idx];
  assign can_extend = ((hw_r + CNT_W'(1)) < CNT_W'(NUM_SLOTS));
  // Owner entries never written read as zero
  assign owner_eff  = wrt_r[paddr_r] ? ram_q : '0;
  assign rel_match  = pend_r && (owner_eff == who);
  assign slot_used  = !free_r[req_idx];

  assign sts.alloc_done = !in_mark || alloc_hit;
  assign sts.scan_last  = (cnt_r == CNT_W'(NUM_SLOTS - 1));

  dsa_ram #(
    .WIDTH (OWNER_BITS),
    .DEPTH (NUM_SLOTS)
  ) u_owner_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (who),
    .raddr (cnt_idx),
    .rdata (ram_q)
  );

  always_comb begin
    req_nxt       = req_r;
    cnt_nxt       = cnt_r;
    count_nxt     = count_r;
    hw_nxt        = hw_r;
    free_nxt      = free_r;
    wrt_nxt       = wrt_r;
    pend_nxt      = 1'b0;
    paddr_nxt     = paddr_r;
    out_valid_nxt = 1'b0;
    res_nxt       = res_r;
    ram_we        = 1'b0;
    ram_waddr     = cnt_idx;

    // Compare the owner read back last cycle; free and count on a match
    if (rel_match) begin
      free_nxt[paddr_r] = 1'b1;
      count_nxt         = count_r + CNT_W'(1);
    end

    if (cmd.load) begin
      req_nxt   = in_req;
      cnt_nxt   = '0;
      count_nxt = '0;
    end

    if (cmd.alloc_step) begin
      if (alloc_hit) begin
        free_nxt[cnt_idx] = 1'b0;
        wrt_nxt[cnt_idx]  = 1'b1;
        ram_we            = 1'b1;
        ram_waddr         = cnt_idx;
        out_valid_nxt     = 1'b1;
        res_nxt           = '0;
        res_nxt.alloc_index = IDX_W'(cnt_idx);
      end else if (!in_mark) begin
        out_valid_nxt = 1'b1;
        res_nxt       = '0;
        if (can_extend) begin
          free_nxt[hw_idx]    = 1'b0;
          wrt_nxt[hw_idx]     = 1'b1;
          ram_we              = 1'b1;
          ram_waddr           = hw_idx;
          hw_nxt              = hw_r + CNT_W'(1);
          res_nxt.alloc_index = IDX_W'(hw_idx);
        end
      end else begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end

    if (cmd.rel_issue) begin
      pend_nxt  = 1'b1;
      paddr_nxt = cnt_idx;
      cnt_nxt   = cnt_r + CNT_W'(1);
    end

    if (cmd.rel_finish) begin
      out_valid_nxt       = 1'b1;
      res_nxt             = '0;
      res_nxt.freed_count = FREED_W'(count_nxt);
    end

    if (cmd.simple_op) begin
      out_valid_nxt = 1'b1;
      res_nxt       = '0;
      if (req_r.req_type == REQ_CHOWN) begin
        if (slot_used) begin
          wrt_nxt[req_idx] = 1'b1;
          ram_we           = 1'b1;
          ram_waddr        = req_idx;
        end
      end else begin
        res_nxt.fd_valid = slot_used;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      count_r     <= '0;
      hw_r        <= CNT_W'(1);
      free_r      <= {{(NUM_SLOTS-1){1'b1}}, 1'b0};
      wrt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      count_r     <= count_nxt;
      hw_r        <= hw_nxt;
      free_r      <= free_nxt;
      wrt_r       <= wrt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r   <= req_nxt;
    paddr_r <= paddr_nxt;
    res_r   <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

endmodule

[rtl/descriptor_slot_allocator.sv]
// Descriptor slot allocator: lowest-free-slot allocation with owner tags.
// From accept to result strobe: change owner and query pass through the simple state;
// allocate tests one slot per cycle up to the high-water mark; release reads the owner
// RAM one slot per cycle, then a drain state empties the read pipe. One item at a time.
// Reset (rst_n low, synchronous): slot 0 held as the null descriptor, all other slots free,
// owners read as zero, high-water mark 1, no result pending. Results cannot be stalled.
module descriptor_slot_allocator
  import dsa_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  dsa_req_t in_req,
  output logic     out_valid,
  output dsa_res_t out_res
);

  dsa_cmd_t cmd;
  dsa_sts_t sts;

  // Controller: steps each request through its states, at most one command per cycle
  dsa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .req_type (in_req.req_type),
    .sts      (sts),
    .cmd      (cmd),
    .busy     (busy)
  );

  // Datapath: free flags, owner RAM, high-water mark, scan counter and result register.
  // The result register is loaded at the end of a request, so the strobe cycle already
  // sees busy low and a new transfer may be started in it.
  dsa_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

`ifndef SYNTHESIS
  // The controller never issues two datapath commands at once
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("more than one datapath command active");

  // An accepted transfer keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("block not busy after accepting a request");

  // A result is shown only once the controller is back at idle
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while a request is still in progress");

  // At most one result field carries a nonzero value
  a_result_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($countones({(out_res.alloc_index != '0), (out_res.freed_count != '0),
                               out_res.fd_valid}) <= 1))
    else $error("result carries more than one nonzero field");
`endif

endmodule
